@@ src/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
// Holds screen geometry, command/result structs and row-mapping helpers.
// No dependencies.
package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;
	localparam int ROW_W   = $clog2(ROWS);
	localparam int COL_W   = 7;
	localparam int ADDR_W  = 11;
	localparam int CELL_W  = 16;

	localparam logic [7:0] SPACE      = 8'h20;
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_BS      = 8'h08;
	localparam logic [7:0] RESET_COLOR = 8'd15;

	localparam logic [3:0] MODE_WRITE  = 4'd0;
	localparam logic [3:0] MODE_DELETE = 4'd1;
	localparam logic [3:0] MODE_UP     = 4'd2;
	localparam logic [3:0] MODE_DOWN   = 4'd3;
	localparam logic [3:0] MODE_LEFT   = 4'd4;
	localparam logic [3:0] MODE_RIGHT  = 4'd5;
	localparam logic [3:0] MODE_HOME   = 4'd6;
	localparam logic [3:0] MODE_READ   = 4'd7;
	localparam logic [3:0] MODE_CLEAR  = 4'd8;

	typedef struct packed {
		logic [3:0]  mode;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} cmd_t;

	typedef struct packed {
		logic [4:0]  cur_row;
		logic [6:0]  cur_col;
		logic [10:0] cursor_pos;
		logic [7:0]  cell_glyph;
		logic [7:0]  cell_color;
	} result_t;

	// logical row -> physical row through the scroll offset
	function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
			input logic [ROW_W-1:0] top);
		logic [ROW_W:0] s;
		s = {1'b0, r} + {1'b0, top};
		if (s >= (ROW_W+1)'(ROWS)) begin
			s = s - (ROW_W+1)'(ROWS);
		end
		return s[ROW_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] prow);
		return ADDR_W'(prow) * ADDR_W'(COLUMNS);
	endfunction

endpackage

@@ src/tcw_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ src/text_console_writer_core.sv @@
// Text console writer: character-cell terminal over a screen RAM.
// Depends on tcw_pkg and tcw_ram.
//
// Usage:
//   A command transaction is taken when start is high and busy is low. The
//   cmd struct carries mode, char_code and cell_index. Every command gives
//   exactly one result transaction: done is high for one cycle with the
//   cursor and, for a cell read, the addressed cell on result. The receiver
//   cannot stall; results are never held. text_color is written through
//   cfg_we/cfg_wdata while idle, a user duty the block does not enforce.
// Command flow: home, clear, CR, NUL, newline, left within a row and unused
//   modes go straight to done; up, down, right and left or delete/backspace
//   across rows scan the row for its last printed column, which a blank row
//   skips; storing a glyph or blank first fills a row that is still blanked;
//   cell reads find the row by repeated subtraction of COLUMNS.
//   One command at a time, next one the cycle after done.
// Scrolling moves a row offset and blanks the new bottom row by a per-row
//   blank flag and color, so rows are never copied.
// Reset: cursor at origin, all rows blank in color 15, text_color 15; no
//   clearing pass, the block is ready the first cycle after reset.
module text_console_writer_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  tcw_pkg::cmd_t    cmd,
	output logic             done,
	output tcw_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata
);

	import tcw_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_DIV    = 10'b0000000010,
		ST_RDCELL = 10'b0000000100,
		ST_RDWAIT = 10'b0000001000,
		ST_SCAN   = 10'b0000010000,
		ST_APPLY  = 10'b0000100000,
		ST_PREP   = 10'b0001000000,
		ST_FILL   = 10'b0010000000,
		ST_WRITE  = 10'b0100000000,
		ST_DONE   = 10'b1000000000
	} state_t;

	typedef enum logic [1:0] {
		ACT_CLAMP,
		ACT_SETCOL,
		ACT_DELSET,
		ACT_RIGHT
	} act_t;

	state_t              state_q;
	act_t                act_q;
	logic [7:0]          color_q;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    top_q;
	logic [ROWS-1:0]     row_vld_q;
	logic [7:0]          row_clr_q [ROWS];
	logic [CELL_W-1:0]   glyph_q;
	logic                inc_q;
	logic [COL_W-1:0]    scan_k_q;
	logic [COL_W-1:0]    fill_k_q;
	logic [COL_W-1:0]    last_q;
	logic                rvalid_s1;
	logic [COL_W-1:0]    col_s1;
	logic [ADDR_W-1:0]   div_rem_q;
	logic [ROW_W-1:0]    div_r_q;
	logic [7:0]          cell_glyph_q;
	logic [7:0]          cell_color_q;

	logic [ROW_W-1:0]    prow;
	logic [ROW_W-1:0]    prow_rd;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_addr;
	logic [CELL_W-1:0]   mem_wdata;
	logic [CELL_W-1:0]   mem_rdata;
	logic                at_bottom;

	assign prow      = phys_row(row_q, top_q);
	assign prow_rd   = phys_row(div_r_q, top_q);
	assign at_bottom = (row_q == ROW_W'(ROWS - 1));

	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = glyph_q;
		case (state_q)
			ST_SCAN: mem_addr = row_base(prow) + ADDR_W'(scan_k_q);
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_addr  = row_base(prow) + ADDR_W'(fill_k_q);
				mem_wdata = {row_clr_q[prow], SPACE};
			end
			ST_WRITE: begin
				mem_we   = 1'b1;
				mem_addr = row_base(prow) + ADDR_W'(col_q);
			end
			ST_RDCELL: mem_addr = row_base(prow_rd) + div_rem_q;
			default: mem_addr = '0;
		endcase
	end

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_s1 <= 1'b0;
			col_s1    <= '0;
		end else begin
			rvalid_s1 <= (state_q == ST_SCAN) && row_vld_q[prow]
				&& (scan_k_q < COL_W'(COLUMNS));
			col_s1    <= scan_k_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			act_q        <= ACT_CLAMP;
			color_q      <= RESET_COLOR;
			row_q        <= '0;
			col_q        <= '0;
			top_q        <= '0;
			row_vld_q    <= '0;
			for (int i = 0; i < ROWS; i++) begin
				row_clr_q[i] <= RESET_COLOR;
			end
			glyph_q      <= '0;
			inc_q        <= 1'b0;
			scan_k_q     <= '0;
			fill_k_q     <= '0;
			last_q       <= '0;
			div_rem_q    <= '0;
			div_r_q      <= '0;
			cell_glyph_q <= '0;
			cell_color_q <= '0;
		end else begin
			if (cfg_we) begin
				color_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cell_glyph_q <= '0;
						cell_color_q <= '0;
						scan_k_q     <= '0;
						last_q       <= '0;
						inc_q        <= 1'b0;
						glyph_q      <= {color_q, SPACE};
						state_q      <= ST_DONE;
						case (cmd.mode)
							MODE_WRITE: begin
								if (cmd.char_code == CH_LF) begin
									col_q <= '0;
									if (!at_bottom) begin
										row_q <= row_q + 1'b1;
									end else begin
										top_q <= (top_q == ROW_W'(ROWS - 1)) ? '0
											: top_q + 1'b1;
										row_vld_q[top_q] <= 1'b0;
										row_clr_q[top_q] <= color_q;
									end
								end else if (cmd.char_code == CH_CR) begin
									col_q <= '0;
								end else if (cmd.char_code == CH_BS) begin
									if (row_q != '0 || col_q != '0) begin
										if (col_q != '0) begin
											col_q   <= col_q - 1'b1;
											state_q <= ST_PREP;
										end else begin
											row_q   <= row_q - 1'b1;
											act_q   <= ACT_DELSET;
											state_q <= ST_SCAN;
										end
									end
								end else if (cmd.char_code != CH_NUL) begin
									glyph_q <= {color_q, cmd.char_code};
									inc_q   <= 1'b1;
									state_q <= ST_PREP;
									if (col_q >= COL_W'(COLUMNS)) begin
										col_q <= '0;
										if (!at_bottom) begin
											row_q <= row_q + 1'b1;
										end else begin
											top_q <= (top_q == ROW_W'(ROWS - 1)) ? '0
												: top_q + 1'b1;
											row_vld_q[top_q] <= 1'b0;
											row_clr_q[top_q] <= color_q;
										end
									end
								end
							end
							MODE_DELETE: begin
								if (row_q != '0 || col_q != '0) begin
									if (col_q != '0) begin
										col_q   <= col_q - 1'b1;
										state_q <= ST_PREP;
									end else begin
										row_q   <= row_q - 1'b1;
										act_q   <= ACT_DELSET;
										state_q <= ST_SCAN;
									end
								end
							end
							MODE_UP: begin
								if (row_q != '0) begin
									row_q   <= row_q - 1'b1;
									act_q   <= ACT_CLAMP;
									state_q <= ST_SCAN;
								end
							end
							MODE_DOWN: begin
								if (!at_bottom) begin
									row_q   <= row_q + 1'b1;
									act_q   <= ACT_CLAMP;
									state_q <= ST_SCAN;
								end
							end
							MODE_LEFT: begin
								if (col_q != '0) begin
									col_q <= col_q - 1'b1;
								end else if (row_q != '0) begin
									row_q   <= row_q - 1'b1;
									act_q   <= ACT_SETCOL;
									state_q <= ST_SCAN;
								end
							end
							MODE_RIGHT: begin
								act_q   <= ACT_RIGHT;
								state_q <= ST_SCAN;
							end
							MODE_HOME: begin
								row_q <= '0;
								col_q <= '0;
							end
							MODE_READ: begin
								if (cmd.cell_index < ADDR_W'(CELLS)) begin
									div_rem_q <= cmd.cell_index;
									div_r_q   <= '0;
									state_q   <= ST_DIV;
								end
							end
							MODE_CLEAR: begin
								row_vld_q <= '0;
								for (int i = 0; i < ROWS; i++) begin
									row_clr_q[i] <= color_q;
								end
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_DIV: begin
					if (div_rem_q >= ADDR_W'(COLUMNS)) begin
						div_rem_q <= div_rem_q - ADDR_W'(COLUMNS);
						div_r_q   <= div_r_q + 1'b1;
					end else begin
						state_q <= ST_RDCELL;
					end
				end
				ST_RDCELL: begin
					if (!row_vld_q[prow_rd]) begin
						cell_glyph_q <= SPACE;
						cell_color_q <= row_clr_q[prow_rd];
						state_q      <= ST_DONE;
					end else begin
						state_q <= ST_RDWAIT;
					end
				end
				ST_RDWAIT: begin
					cell_glyph_q <= mem_rdata[7:0];
					cell_color_q <= mem_rdata[15:8];
					state_q      <= ST_DONE;
				end
				ST_SCAN: begin
					if (!row_vld_q[prow]) begin
						state_q <= ST_APPLY;
					end else begin
						if (scan_k_q < COL_W'(COLUMNS)) begin
							scan_k_q <= scan_k_q + 1'b1;
						end
						if (rvalid_s1 && mem_rdata[7:0] != SPACE) begin
							last_q <= col_s1 + 1'b1;
						end
						if (rvalid_s1 && col_s1 == COL_W'(COLUMNS - 1)) begin
							state_q <= ST_APPLY;
						end
					end
				end
				ST_APPLY: begin
					state_q <= ST_DONE;
					case (act_q)
						ACT_CLAMP: begin
							if (col_q > last_q) begin
								col_q <= last_q;
							end
						end
						ACT_SETCOL: col_q <= last_q;
						ACT_DELSET: begin
							col_q <= last_q;
							if (last_q < COL_W'(COLUMNS)) begin
								state_q <= ST_PREP;
							end
						end
						ACT_RIGHT: begin
							if (col_q < last_q) begin
								col_q <= col_q + 1'b1;
							end else if (!at_bottom) begin
								row_q <= row_q + 1'b1;
								col_q <= '0;
							end
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_PREP: begin
					fill_k_q <= '0;
					state_q  <= row_vld_q[prow] ? ST_WRITE : ST_FILL;
				end
				ST_FILL: begin
					fill_k_q <= fill_k_q + 1'b1;
					if (fill_k_q == COL_W'(COLUMNS - 1)) begin
						row_vld_q[prow] <= 1'b1;
						state_q         <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (inc_q) begin
						col_q <= col_q + 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy              = (state_q != ST_IDLE);
	assign done              = (state_q == ST_DONE);
	assign result.cur_row    = 5'(row_q);
	assign result.cur_col    = col_q;
	assign result.cursor_pos = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
	assign result.cell_glyph = cell_glyph_q;
	assign result.cell_color = cell_color_q;

endmodule

@@ src/tcw_checker.sv @@
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_core.
module tcw_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input tcw_pkg::result_t result
);

	import tcw_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result while idle");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result not a single-cycle pulse");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.cur_col <= 7'(COLUMNS) && result.cur_row < 5'(ROWS))
		else $error("cursor out of range");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);
